>>> hdl/detection_event_qualifier_core_assert.svh
// Assertion macros for the detection event qualifier
`ifndef DETECTION_EVENT_QUALIFIER_CORE_ASSERT_SVH
`define DETECTION_EVENT_QUALIFIER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DEQ_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deq assertion failed");

// next-cycle implication, disabled during reset
`define DEQ_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deq assertion failed");

// next-cycle implication, checked through reset
`define DEQ_AST_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("deq assertion failed");

`endif

>>> hdl/deq_pkg.sv
// Shared types and constants for the detection event qualifier
package deq_pkg;

    localparam int unsigned ScoreW = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned HitsW  = 8;
    localparam int unsigned WinW   = 16;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CfgScoreThr = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgMinHits  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgWindow   = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgCooldown = 2'd3;

    localparam logic [ScoreW-1:0] RstScoreThr = 16'd62259;
    localparam logic [HitsW-1:0]  RstMinHits  = 8'd2;
    localparam logic [WinW-1:0]   RstWindow   = 16'd1200;
    localparam logic [WinW-1:0]   RstCooldown = 16'd1500;

    localparam logic [HitsW-1:0]  HitsMax     = 8'd255;

    typedef struct packed {
        logic [ScoreW-1:0] score;
        logic [TimeW-1:0]  time_ms;
    } t_deq_in;

    typedef struct packed {
        logic              event_fire;
        logic [HitsW-1:0]  pending_hits;
    } t_deq_out;

endpackage

>>> hdl/detection_event_qualifier_core.sv
// Detection event qualifier: score debounce with run window and cooldown
//
// Input channel: i_in_valid / o_in_stall carry one request (score, time_ms).
// Output channel: o_out_valid / i_out_stall carry one result per request
// (event_fire, pending_hits). Configuration: i_cfg_we writes i_cfg_data to
// the register chosen by i_cfg_idx (threshold, min hits, window, cooldown);
// write only while no request is in flight.
// Pipeline: input register r_in, then output register r_out.
// Throughput: one request per cycle unless i_out_stall holds the result; the
// run state (hit count, run start, last event time) is read and updated in
// the same cycle the result is registered, so requests chain without a bubble.
// Stall: while the result register is held by i_out_stall, one more request
// is taken into the input register; after that o_in_stall rises.
// Reset: synchronous, active low; clears both stages, the run state and
// restores the default register values.
module detection_event_qualifier_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  deq_pkg::t_deq_in             i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output deq_pkg::t_deq_out            o_out_data,
    input  logic                         i_cfg_we,
    input  logic [deq_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [deq_pkg::CfgW-1:0]     i_cfg_data
);

    logic [deq_pkg::ScoreW-1:0] r_thr;
    logic [deq_pkg::HitsW-1:0]  r_min_hits;
    logic [deq_pkg::WinW-1:0]   r_window;
    logic [deq_pkg::WinW-1:0]   r_cooldown;

    logic                       r_in_valid;
    deq_pkg::t_deq_in           r_in;
    logic                       r_out_valid;
    deq_pkg::t_deq_out          r_out;

    logic [deq_pkg::HitsW-1:0]  r_hits;
    logic [deq_pkg::TimeW-1:0]  r_start;
    logic [deq_pkg::TimeW-1:0]  r_last;

    logic [deq_pkg::HitsW-1:0]  n_hits;
    logic [deq_pkg::TimeW-1:0]  n_start;
    logic [deq_pkg::TimeW-1:0]  n_last;
    deq_pkg::t_deq_out          n_out;

    logic                       out_free;
    logic                       advance;
    logic                       in_take;
    logic                       miss;
    logic                       cooling;
    logic                       restart;
    logic [deq_pkg::TimeW-1:0]  since_event;
    logic [deq_pkg::TimeW-1:0]  run_age;
    logic [deq_pkg::HitsW-1:0]  base_hits;
    logic [deq_pkg::HitsW-1:0]  inc_hits;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        since_event = r_in.time_ms - r_last;
        run_age     = r_in.time_ms - r_start;
        miss        = r_in.score < r_thr;
        cooling     = (r_last != '0) && (r_cooldown != '0) &&
                      (since_event < {{(deq_pkg::TimeW-deq_pkg::WinW){1'b0}}, r_cooldown});
        restart     = (r_hits == '0) ||
                      ((r_window != '0) &&
                       (run_age > {{(deq_pkg::TimeW-deq_pkg::WinW){1'b0}}, r_window}));
        base_hits   = restart ? '0 : r_hits;
        inc_hits    = (base_hits == deq_pkg::HitsMax) ? base_hits
                                                      : base_hits + 1'b1;
        n_hits      = r_hits;
        n_start     = r_start;
        n_last      = r_last;
        n_out.event_fire = 1'b0;
        if (miss) begin
            n_hits  = '0;
            n_start = '0;
        end else if (!cooling) begin
            n_hits  = inc_hits;
            n_start = restart ? r_in.time_ms : r_start;
            if (inc_hits >= r_min_hits) begin
                n_out.event_fire = 1'b1;
                n_hits  = '0;
                n_start = '0;
                n_last  = r_in.time_ms;
            end
        end
        n_out.pending_hits = n_hits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= deq_pkg::RstScoreThr;
            r_min_hits <= deq_pkg::RstMinHits;
            r_window   <= deq_pkg::RstWindow;
            r_cooldown <= deq_pkg::RstCooldown;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                deq_pkg::CfgScoreThr: r_thr      <= i_cfg_data;
                deq_pkg::CfgMinHits:  r_min_hits <= i_cfg_data[deq_pkg::HitsW-1:0];
                deq_pkg::CfgWindow:   r_window   <= i_cfg_data;
                deq_pkg::CfgCooldown: r_cooldown <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_start     <= '0;
            r_last      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_hits      <= n_hits;
                r_start     <= n_start;
                r_last      <= n_last;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hdl/deq_checker.sv
// Port-level checker for the detection event qualifier, bound to the top level
`include "detection_event_qualifier_core_assert.svh"

module deq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input deq_pkg::t_deq_out o_out_data
);

    `DEQ_AST_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `DEQ_AST_IMP(a_fire_clears, o_out_valid && o_out_data.event_fire, o_out_data.pending_hits == '0)
    `DEQ_AST_IMP(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)
    `DEQ_AST_RST(a_rst_empty, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind detection_event_qualifier_core deq_checker u_deq_checker (.*);
